// ===== hdl/positional_list_engine_unit_macros.svh =====
// assertion macros shared by the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// condition must hold at every edge outside reset
`define PLEU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PLEU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PLEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pleu_pkg.sv =====
// package with types, codes and defaults of the positional list engine
package pleu_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned REQ_TYPE_W = 3;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 9;

  // request codes
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ADD_FRONT    = 3'd0,
    REQ_ADD_REAR     = 3'd1,
    REQ_REMOVE_FRONT = 3'd2,
    REQ_REMOVE_REAR  = 3'd3,
    REQ_INSERT_AT    = 3'd4,
    REQ_REMOVE_AT    = 3'd5
  } req_type_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // action broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  // controller states
  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_BUSY = 2'd1,
    CTL_DONE = 2'd2
  } ctl_state_e;

  // request transaction payload
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    value;
  } req_t;

  // result transaction payload
  typedef struct packed {
    logic [VALUE_W-1:0]  removed_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count_after;
  } rsp_t;

endpackage

// ===== hdl/pleu_cell.sv =====
// one storage cell of the element chain
module pleu_cell #(
  parameter int unsigned IW  = 8,
  parameter int unsigned W   = 32,
  parameter int unsigned POS = 0
) (
  input  logic               clk_i,
  input  pleu_pkg::cell_op_e op_i,
  input  logic [IW-1:0]      idx_i,
  input  logic [W-1:0]       value_i,
  input  logic [W-1:0]       left_i,
  input  logic [W-1:0]       right_i,
  output logic [W-1:0]       val_o,
  output logic [W-1:0]       tap_o
);
  import pleu_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(POS);

  logic [W-1:0] val_q;
  logic [W-1:0] val_d;

  // insert shifts toward the rear, remove pulls from the rear neighbor
  always_comb begin
    val_d = val_q;
    case (op_i)
      CELL_INSERT: begin
        if (MY_IDX > idx_i) begin
          val_d = left_i;
        end else if (MY_IDX == idx_i) begin
          val_d = value_i;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= idx_i) begin
          val_d = right_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  // element register
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // hand out the element being removed, zero otherwise
  assign tap_o = (op_i == CELL_REMOVE && MY_IDX == idx_i) ? val_q : '0;
  assign val_o = val_q;

endmodule

// ===== hdl/pleu_or_tree.sv =====
// registered radix-4 or tree that collects the removed element from the cells
module pleu_or_tree #(
  parameter int unsigned LEAVES = 256,
  parameter int unsigned W      = 32
) (
  input  logic         clk_i,
  input  logic [W-1:0] taps_i [LEAVES],
  output logic [W-1:0] root_o
);

  localparam int unsigned LEVELS = ($clog2(LEAVES) + 1) / 2;
  localparam int unsigned PADDED = 4 ** LEVELS;
  localparam int unsigned NODES  = (PADDED - 1) / 3;

  logic [W-1:0] leaf   [PADDED];
  logic [W-1:0] node_q [NODES];

  // pad the leaf row up to a power of four
  for (genvar i = 0; i < PADDED; i++) begin : g_leaf
    if (i < LEAVES) begin : g_tap
      assign leaf[i] = taps_i[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // one register level per tree level, root at node zero
  for (genvar d = 0; d < LEVELS; d++) begin : g_lvl
    localparam int unsigned OFF  = (4 ** d - 1) / 3;
    localparam int unsigned COFF = (4 ** (d + 1) - 1) / 3;
    for (genvar j = 0; j < 4 ** d; j++) begin : g_node
      if (d == LEVELS - 1) begin : g_bottom
        always_ff @(posedge clk_i) begin
          node_q[OFF+j] <= leaf[4*j] | leaf[4*j+1] | leaf[4*j+2] | leaf[4*j+3];
        end
      end else begin : g_inner
        always_ff @(posedge clk_i) begin
          node_q[OFF+j] <= node_q[COFF+4*j] | node_q[COFF+4*j+1]
                         | node_q[COFF+4*j+2] | node_q[COFF+4*j+3];
        end
      end
    end
  end

  assign root_o = node_q[0];

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
// top level of the positional list engine: controller, cell chain and readout tree
//
// Bounded ordered list of up to CAPACITY elements, front at position 1.
// Request channel (in_valid_i, in_stall_o, in_req_i): add front, add rear,
// remove front, remove rear, insert at a 1-based position, remove at one.
// Result channel (out_valid_o, out_stall_i, out_rsp_o): one result per
// request with the removed element (zero unless a removal succeeded), a
// status code and the element count after the request.
// A transaction moves at a clock edge where valid is high and stall is low.
// The cell chain shifts all elements above the position in the cycle the
// request is taken. The removed element is gathered by a registered radix-4
// or tree of L = ceil(log4(CAPACITY)) levels (4 at CAPACITY 256).
// One request is in flight at a time: the result takes the removed element
// from the tree root once the wait counter has run out.
// A result waits in its output register for as long as out_stall_i holds;
// no new request is taken until it leaves.
// Reset empties the list at once; element storage needs no clearing.
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit #(
  parameter int unsigned CAPACITY   = pleu_pkg::CAPACITY_DEF,
  parameter int unsigned ELEM_WIDTH = pleu_pkg::ELEM_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pleu_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pleu_pkg::rsp_t out_rsp_o
);
  import pleu_pkg::*;

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned IW     = $clog2(CAPACITY);
  localparam int unsigned LEVELS = ($clog2(CAPACITY) + 1) / 2;
  localparam int unsigned CNTW   = $clog2(LEVELS + 1);
  localparam int unsigned CMPW   = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [CW-1:0]   CAP_CNT   = CW'(CAPACITY);
  localparam logic [CNTW-1:0] WAIT_INIT = CNTW'(LEVELS - 1);

  ctl_state_e state_q, state_d;
  logic [CNTW-1:0] wait_q, wait_d;
  logic [CW-1:0]   count_q, count_d;
  rsp_t            rsp_q, rsp_d;

  logic in_accept;
  logic out_fire;
  logic tree_done;

  cell_op_e             dec_op;
  logic [IW-1:0]        dec_idx;
  status_e              dec_status;
  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic                 list_full;
  logic                 list_empty;

  cell_op_e             cell_op;
  logic [ELEM_WIDTH-1:0] new_value;
  logic [ELEM_WIDTH-1:0] cell_val [CAPACITY];
  logic [ELEM_WIDTH-1:0] cell_tap [CAPACITY];
  logic [ELEM_WIDTH-1:0] root;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_fire  = out_valid_o && !out_stall_i;

  // request decode against the current count
  assign pos_ext    = CMPW'(in_req_i.position);
  assign cnt_ext    = CMPW'(count_q);
  assign list_full  = (count_q == CAP_CNT);
  assign list_empty = (count_q == '0);

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_idx    = '0;
    dec_status = ST_OK;
    case (in_req_i.req_type)
      REQ_ADD_FRONT: begin
        if (list_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op = CELL_INSERT;
        end
      end
      REQ_ADD_REAR: begin
        if (list_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op  = CELL_INSERT;
          dec_idx = count_q[IW-1:0];
        end
      end
      REQ_REMOVE_FRONT: begin
        if (list_empty) begin
          dec_status = ST_UNDER;
        end else begin
          dec_op = CELL_REMOVE;
        end
      end
      REQ_REMOVE_REAR: begin
        if (list_empty) begin
          dec_status = ST_UNDER;
        end else begin
          dec_op  = CELL_REMOVE;
          dec_idx = IW'(cnt_ext - CMPW'(1));
        end
      end
      REQ_INSERT_AT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
          dec_status = ST_RANGE;
        end else if (list_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op  = CELL_INSERT;
          dec_idx = IW'(pos_ext - CMPW'(1));
        end
      end
      REQ_REMOVE_AT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op  = CELL_REMOVE;
          dec_idx = IW'(pos_ext - CMPW'(1));
        end
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
  end

  // count update
  always_comb begin
    count_d = count_q;
    if (in_accept) begin
      case (dec_op)
        CELL_INSERT: count_d = count_q + CW'(1);
        CELL_REMOVE: count_d = count_q - CW'(1);
        default:     count_d = count_q;
      endcase
    end
  end

  // controller next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (in_accept) begin
          state_d = CTL_BUSY;
        end
      end
      CTL_BUSY: begin
        if (tree_done) begin
          state_d = CTL_DONE;
        end
      end
      CTL_DONE: begin
        if (out_fire) begin
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall_o  = (state_q != CTL_IDLE);
    out_valid_o = (state_q == CTL_DONE);
    tree_done   = (state_q == CTL_BUSY) && (wait_q == '0);
  end

  // wait counter for the readout tree
  always_comb begin
    wait_d = wait_q;
    if (in_accept) begin
      wait_d = WAIT_INIT;
    end else if (state_q == CTL_BUSY && wait_q != '0) begin
      wait_d = wait_q - CNTW'(1);
    end
  end

  // result register: status and count at accept, element once the tree drains
  always_comb begin
    rsp_d = rsp_q;
    if (in_accept) begin
      rsp_d.removed_value = '0;
      rsp_d.status        = dec_status;
      rsp_d.count_after   = COUNT_W'(count_d);
    end else if (tree_done) begin
      rsp_d.removed_value = VALUE_W'(root);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      wait_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      count_q <= count_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_rsp_o = rsp_q;

  // cell chain, front at cell zero
  assign cell_op   = in_accept ? dec_op : CELL_HOLD;
  assign new_value = ELEM_WIDTH'(in_req_i.value);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left;
    logic [ELEM_WIDTH-1:0] right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[k+1];
    end
    pleu_cell #(
      .IW  (IW),
      .W   (ELEM_WIDTH),
      .POS (k)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .idx_i   (dec_idx),
      .value_i (new_value),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[k]),
      .tap_o   (cell_tap[k])
    );
  end

  // readout of the removed element
  pleu_or_tree #(
    .LEAVES (CAPACITY),
    .W      (ELEM_WIDTH)
  ) u_tree (
    .clk_i  (clk_i),
    .taps_i (cell_tap),
    .root_o (root)
  );

  // checks
  `PLEU_ASSERT_ALWAYS(a_count_bound, count_q <= CAP_CNT, "element count above capacity")
  `PLEU_ASSERT_NEXT(a_insert_count, cell_op == CELL_INSERT,
                    count_q == $past(count_q) + CW'(1), "insert did not grow the count")
  `PLEU_ASSERT_IMPL(a_zero_on_error, out_valid_o && rsp_q.status != ST_OK,
                    rsp_q.removed_value == '0, "failed request returned an element")
  `PLEU_ASSERT_IMPL(a_single_flight, state_q != CTL_IDLE, in_stall_o,
                    "request taken while one is in flight")

endmodule
